>>> rtl/assert_macros.svh
// Assertion helpers shared by the allocator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

// Invariant that holds at every edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

`endif

>>> rtl/pba_pkg.sv
package pba_pkg;

   localparam int NUM_ORDERS   = 13;
   localparam int ADDR_BITS    = 12;
   localparam int ORDER_BITS   = 4;
   localparam int COUNT_BITS   = ADDR_BITS + 1;
   localparam int ORD_IDX_BITS = $clog2(NUM_ORDERS);
   localparam int LINK_DEPTH   = 1 << ADDR_BITS;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   typedef logic [ADDR_BITS-1:0]    addr_type;
   typedef logic [COUNT_BITS-1:0]   count_type;
   typedef logic [ORD_IDX_BITS-1:0] ord_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP,
      ST_SPLIT,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      CNT_NONE,
      CNT_ADD,
      CNT_SUB
   } cnt_op_type;

   typedef struct packed {
      logic                  func;
      logic [ORDER_BITS-1:0] order;
      addr_type              address;
   } req_type;

   typedef struct packed {
      logic     we;
      addr_type addr;
      addr_type data;
   } link_wr_type;

   typedef struct packed {
      logic      valid;
      addr_type  granted_address;
      logic      ok;
      count_type free_count;
   } done_type;

endpackage

>>> rtl/pba_link_ram.sv
module pba_link_ram
   import pba_pkg::*;
(
   input  logic        clock,
   input  link_wr_type link_wr,
   input  addr_type    link_raddr,
   output addr_type    link_rdata
);

   addr_type links_ff [LINK_DEPTH];
   addr_type link_rdata_ff;

   always_ff @(posedge clock) begin
      if (link_wr.we) begin
         links_ff[link_wr.addr] <= link_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      link_rdata_ff <= links_ff[link_raddr];
   end

   assign link_rdata = link_rdata_ff;

endmodule

>>> rtl/pba_ctrl.sv
`include "assert_macros.svh"

module pba_ctrl
   import pba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req,
   output link_wr_type link_wr,
   output addr_type    link_raddr,
   input  addr_type    link_rdata,
   output done_type    done,
   input  logic        done_take
);

   localparam count_type COUNT_MAX = {1'b1, {ADDR_BITS{1'b0}}};

   state_type             state_ff, state_in;
   logic                  func_ff;
   logic [ORDER_BITS-1:0] ord_ff;
   addr_type              addr_ff;
   ord_idx_type           cur_ff, cur_in;
   addr_type              base_ff, base_in;
   addr_type              granted_ff, granted_in;
   logic                  ok_ff, ok_in;
   addr_type              heads_ff [NUM_ORDERS];
   count_type             free_blocks_ff, free_blocks_in;

   logic                  order_ok;
   ord_idx_type           ord_idx;
   logic [NUM_ORDERS-1:0] avail;
   logic                  found;
   ord_idx_type           search_idx;
   ord_idx_type           split_k;
   addr_type              half;
   ord_idx_type           head_ridx;
   addr_type              head_rd;
   logic                  head_we;
   ord_idx_type           head_widx;
   addr_type              head_wval;
   cnt_op_type            cnt_op;
   ord_idx_type           cnt_k;
   logic                  cnt_big;
   count_type             cnt_pow;
   logic [COUNT_BITS:0]   cnt_sum;

   assign order_ok = {1'b0, ord_ff} < (ORDER_BITS + 1)'(NUM_ORDERS);
   assign ord_idx  = ORD_IDX_BITS'(ord_ff);
   assign split_k  = cur_ff - ORD_IDX_BITS'(1);
   assign half     = base_ff + (addr_type'(1) << split_k);

   // lowest non-empty list at or above the requested order
   always_comb begin
      found      = 1'b0;
      search_idx = '0;
      for (int i = NUM_ORDERS - 1; i >= 0; i--) begin
         avail[i] = (heads_ff[i] != '0) && (i >= int'(ord_ff));
         if (avail[i]) begin
            found      = 1'b1;
            search_idx = ORD_IDX_BITS'(i);
         end
      end
   end

   always_comb begin
      head_ridx = ord_idx;
      if (state_ff == ST_EXEC && func_ff == FUNC_ALLOC) begin
         head_ridx = search_idx;
      end else if (state_ff == ST_SPLIT) begin
         head_ridx = split_k;
      end
   end
   assign head_rd = heads_ff[head_ridx];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (order_ok && func_ff == FUNC_ALLOC && found) begin
               state_in = ST_POP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_POP: begin
            state_in = (cur_ff > ord_idx) ? ST_SPLIT : ST_DONE;
         end
         ST_SPLIT: begin
            if (split_k == ord_idx) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (done_take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_stall  = 1'b1;
      link_wr    = '0;
      link_raddr = base_ff;
      head_we    = 1'b0;
      head_widx  = ord_idx;
      head_wval  = addr_ff;
      cnt_op     = CNT_NONE;
      cnt_k      = ord_idx;
      cur_in     = cur_ff;
      base_in    = base_ff;
      granted_in = granted_ff;
      ok_in      = ok_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_EXEC: begin
            granted_in = '0;
            ok_in      = 1'b0;
            if (order_ok) begin
               if (func_ff == FUNC_FREE) begin
                  if (addr_ff != '0) begin
                     link_wr   = '{we: 1'b1, addr: addr_ff, data: head_rd};
                     head_we   = 1'b1;
                     head_widx = ord_idx;
                     head_wval = addr_ff;
                     cnt_op    = CNT_ADD;
                     cnt_k     = ord_idx;
                     ok_in     = 1'b1;
                  end
               end else if (found) begin
                  link_raddr = head_rd;
                  base_in    = head_rd;
                  cur_in     = search_idx;
                  cnt_op     = CNT_SUB;
                  cnt_k      = search_idx;
                  granted_in = head_rd;
                  ok_in      = 1'b1;
               end
            end
         end
         ST_POP: begin
            head_we   = 1'b1;
            head_widx = cur_ff;
            head_wval = link_rdata;
         end
         ST_SPLIT: begin
            cur_in = split_k;
            if (half != '0) begin
               link_wr   = '{we: 1'b1, addr: half, data: head_rd};
               head_we   = 1'b1;
               head_widx = split_k;
               head_wval = half;
               cnt_op    = CNT_ADD;
               cnt_k     = split_k;
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   assign done = '{valid: (state_ff == ST_DONE), granted_address: granted_ff,
                   ok: ok_ff, free_count: free_blocks_ff};

   // saturating count update
   assign cnt_big = int'(cnt_k) >= ADDR_BITS;
   assign cnt_pow = cnt_big ? '0 : (count_type'(1) << cnt_k);
   assign cnt_sum = {1'b0, free_blocks_ff} + {1'b0, cnt_pow};

   always_comb begin
      free_blocks_in = free_blocks_ff;
      case (cnt_op)
         CNT_ADD: begin
            if (cnt_big || cnt_sum >= {1'b0, COUNT_MAX}) begin
               free_blocks_in = COUNT_MAX;
            end else begin
               free_blocks_in = cnt_sum[COUNT_BITS-1:0];
            end
         end
         CNT_SUB: begin
            if (cnt_big || cnt_pow >= free_blocks_ff) begin
               free_blocks_in = '0;
            end else begin
               free_blocks_in = free_blocks_ff - cnt_pow;
            end
         end
         default: free_blocks_in = free_blocks_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         free_blocks_ff <= '0;
         for (int i = 0; i < NUM_ORDERS; i++) begin
            heads_ff[i] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         free_blocks_ff <= free_blocks_in;
         if (head_we) begin
            heads_ff[head_widx] <= head_wval;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         func_ff <= req.func;
         ord_ff  <= req.order;
         addr_ff <= req.address;
      end
      cur_ff     <= cur_in;
      base_ff    <= base_in;
      granted_ff <= granted_in;
      ok_ff      <= ok_in;
   end

   `ASSERT_IMPLY(a_split_above_order, clock, reset, state_ff == ST_SPLIT, cur_ff > ord_idx)
   `ASSERT_IMPLY(a_no_link_at_zero, clock, reset, link_wr.we, link_wr.addr != '0)
   `ASSERT_ALWAYS(a_count_bounded, clock, reset, free_blocks_ff <= COUNT_MAX)

endmodule

>>> rtl/power_of_two_block_allocator.sv
// Power-of-two run allocator with one LIFO free list per order (0 .. 12) and
// buddies that are never merged. A free transaction pushes its address onto
// the list of its order and adds 2^order to a saturating free count; a free
// of address 0 or any transaction with an order of 13 or more is rejected
// (ok low, nothing changes). An allocate transaction pops the first non-empty
// list at or above the requested order and pushes the upper halves back down
// one order at a time, skipping a half whose address wraps to 0; it answers
// address 0 with ok low when nothing is available. Every transaction returns
// exactly one response carrying the free count after it. The lists are linked
// through a 4096-entry link RAM with one write and one registered read port;
// link entries are not cleared by reset. One transaction at a time: a free or
// rejected transaction passes the execute and done states before the next one
// is accepted; an allocate adds a pop state that waits for the registered RAM
// read and a split state per split, each half written on the single RAM write
// port. The response sits in an output register, so the next transaction is
// accepted while a response still waits on rsp_stall.
`include "assert_macros.svh"

module power_of_two_block_allocator
   import pba_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_func,
   input  logic [ORDER_BITS-1:0] req_order,
   input  logic [ADDR_BITS-1:0]  req_address,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ADDR_BITS-1:0]  rsp_granted_address,
   output logic                  rsp_ok,
   output logic [COUNT_BITS-1:0] rsp_free_count
);

   req_type     req;
   link_wr_type link_wr;
   addr_type    link_raddr;
   addr_type    link_rdata;
   done_type    done;
   logic        done_take;

   logic        rsp_valid_ff, rsp_valid_in;
   addr_type    rsp_addr_ff;
   logic        rsp_ok_ff;
   count_type   rsp_count_ff;

   assign req = '{func: req_func, order: req_order, address: req_address};

   pba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req        (req),
      .link_wr    (link_wr),
      .link_raddr (link_raddr),
      .link_rdata (link_rdata),
      .done       (done),
      .done_take  (done_take)
   );

   pba_link_ram u_link_ram (
      .clock      (clock),
      .link_wr    (link_wr),
      .link_raddr (link_raddr),
      .link_rdata (link_rdata)
   );

   // Output slot is free when empty or being drained this cycle.
   assign done_take = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done_take) begin
         rsp_valid_in = done.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the payload only with a new response; hold it while stalled.
   always_ff @(posedge clock) begin
      if (done_take && done.valid) begin
         rsp_addr_ff  <= done.granted_address;
         rsp_ok_ff    <= done.ok;
         rsp_count_ff <= done.free_count;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_ok              = rsp_ok_ff;
   assign rsp_free_count      = rsp_count_ff;

   `ASSERT_IMPLY(a_fail_no_grant, clock, reset, rsp_valid_ff && !rsp_ok_ff, rsp_addr_ff == '0)

endmodule
